>>> rtl/aba_pkg.sv
// shared types and constants for the arena bump allocator
package aba_pkg;

  // block table depth; index and count port widths are sized for it
  localparam int MAX_BLOCKS = 16;

  localparam int SIZE_W  = 24;
  localparam int CAP_W   = 25;
  localparam int IDX_W   = 4;
  localparam int ALLOC_W = 32;
  localparam int USED_W  = 48;
  localparam int RSV_W   = 30;
  localparam int TOTAL_W = 5;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_REWIND  = 2'd1;
  localparam logic [1:0] REQ_DESTROY = 2'd2;

  localparam logic [SIZE_W-1:0] DFLT_SIZE_RST = 24'd4096;
  localparam logic [USED_W-1:0] USED_MAX      = {USED_W{1'b1}};
  localparam logic [RSV_W-1:0]  RSV_MAX       = {RSV_W{1'b1}};

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // search token walking down the block chain
  typedef struct packed {
    logic              valid;
    logic              found;
    logic              created;
    logic [SIZE_W-1:0] size;
    logic [CAP_W-1:0]  cap_new;
    logic [IDX_W-1:0]  idx;
    logic [CAP_W-1:0]  offset;
  } tok_t;

endpackage

>>> rtl/aba_cell.sv
// one block slot: capacity and fill, serves or creates when the token passes
module aba_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear_fill,
  input  logic [CNT_W-1:0]  blk_count,
  input  aba_pkg::tok_t     tok_in,
  output aba_pkg::tok_t     tok_out
);

  logic [aba_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [aba_pkg::CAP_W-1:0] fill_r, fill_nxt;
  aba_pkg::tok_t             tok_r, tok_nxt;

  logic [aba_pkg::CAP_W-1:0] room;
  logic [aba_pkg::CAP_W-1:0] size_ext;
  logic                      in_use;
  logic                      at_end;

  always_comb begin
    room     = cap_r - fill_r;
    size_ext = {1'b0, tok_in.size};
    in_use   = CNT_W'(CELL_IDX) < blk_count;
    at_end   = CNT_W'(CELL_IDX) == blk_count;
    cap_nxt  = cap_r;
    fill_nxt = fill_r;
    tok_nxt  = tok_in;
    if (clear_fill) begin
      fill_nxt = '0;
    end
    if (tok_in.valid && !tok_in.found) begin
      if (in_use && (size_ext <= room)) begin
        // first block with room takes it
        tok_nxt.found  = 1'b1;
        tok_nxt.idx    = aba_pkg::IDX_W'(CELL_IDX);
        tok_nxt.offset = fill_r;
        fill_nxt       = fill_r + size_ext;
      end else if (at_end) begin
        // no earlier block fit: open this slot
        tok_nxt.found   = 1'b1;
        tok_nxt.created = 1'b1;
        tok_nxt.idx     = aba_pkg::IDX_W'(CELL_IDX);
        tok_nxt.offset  = '0;
        cap_nxt         = tok_in.cap_new;
        fill_nxt        = size_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_r  <= cap_nxt;
    fill_r <= fill_nxt;
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/block_arena_bump_allocator.sv
// top level of the arena bump allocator: request control, totals and block chain
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  in      | in_req_type, in_alloc_size              | start high, busy low
//  out     | out_ok ... out_block_total              | out_valid, one cycle, no stall
//  cfg     | cfg_data (default block size)           | cfg_valid and cfg_ready
//
// an allocate item walks the chain of MAX_BLOCKS cells, one cell per cycle;
// its token is registered at entry and in each cell, and its result at the output
// rewind, destroy and unknown codes answer in the next cycle
// busy is high while an allocate item is in the chain, until the result cycle;
// a new item can be taken in the cycle its predecessor's result is shown
// synchronous active-low reset clears counters, state and default size
// block slots are not cleared: only slots below the block count are read
module block_arena_bump_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [23:0] in_alloc_size,
  // result output
  output logic        out_valid,
  output logic        out_ok,
  output logic [3:0]  out_block_index,
  output logic [24:0] out_offset,
  output logic [31:0] out_allocation_total,
  output logic [47:0] out_used_total,
  output logic [29:0] out_reserved_total,
  output logic [4:0]  out_block_total,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  localparam int MAX_BLOCKS = aba_pkg::MAX_BLOCKS;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // control and totals
  aba_pkg::state_t               state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [aba_pkg::ALLOC_W-1:0]   alloc_r, alloc_nxt;
  logic [aba_pkg::USED_W-1:0]    used_r, used_nxt;
  logic [aba_pkg::RSV_W-1:0]     rsv_r, rsv_nxt;
  logic [aba_pkg::SIZE_W-1:0]    dflt_r, dflt_nxt;

  // result registers
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_ok_r, out_ok_nxt;
  logic [aba_pkg::IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [aba_pkg::CAP_W-1:0]     out_off_r, out_off_nxt;

  // token entering the chain
  aba_pkg::tok_t                 tok0_r, tok0_nxt;
  aba_pkg::tok_t                 tok_w [MAX_BLOCKS+1];
  aba_pkg::tok_t                 tok_last;

  logic                          accept;
  logic                          clear_fill;
  logic [aba_pkg::CAP_W-1:0]     cap_new;
  logic [aba_pkg::USED_W:0]      used_sum;
  logic [aba_pkg::RSV_W:0]       rsv_sum;

  assign tok_w[0] = tok0_r;
  assign tok_last = tok_w[MAX_BLOCKS];

  // the chain of block slots
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    aba_cell #(
      .CELL_IDX (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clear_fill (clear_fill),
      .blk_count  (count_r),
      .tok_in     (tok_w[g]),
      .tok_out    (tok_w[g+1])
    );
  end

  always_comb begin
    accept     = start && (state_r == aba_pkg::ST_IDLE);
    clear_fill = 1'b0;

    // new-block capacity: doubled size for large items, else the default
    if (in_alloc_size > (dflt_r >> 1)) begin
      cap_new = {in_alloc_size, 1'b0};
    end else begin
      cap_new = {1'b0, dflt_r};
    end

    used_sum = {1'b0, used_r} + {{(aba_pkg::USED_W - aba_pkg::SIZE_W + 1){1'b0}}, tok_last.size};
    rsv_sum  = {1'b0, rsv_r} + {{(aba_pkg::RSV_W - aba_pkg::CAP_W + 1){1'b0}}, tok_last.cap_new};

    state_nxt     = state_r;
    count_nxt     = count_r;
    alloc_nxt     = alloc_r;
    used_nxt      = used_r;
    rsv_nxt       = rsv_r;
    dflt_nxt      = dflt_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_off_nxt   = out_off_r;
    tok0_nxt      = tok0_r;
    tok0_nxt.valid = 1'b0;

    if (cfg_valid && cfg_ready) begin
      dflt_nxt = cfg_data;
    end

    unique case (state_r)
      aba_pkg::ST_IDLE: begin
        if (accept) begin
          out_idx_nxt = '0;
          out_off_nxt = '0;
          out_ok_nxt  = 1'b1;
          unique case (in_req_type)
            aba_pkg::REQ_ALLOC: begin
              // launch the search token down the chain
              tok0_nxt.valid   = 1'b1;
              tok0_nxt.found   = 1'b0;
              tok0_nxt.created = 1'b0;
              tok0_nxt.size    = in_alloc_size;
              tok0_nxt.cap_new = cap_new;
              tok0_nxt.idx     = '0;
              tok0_nxt.offset  = '0;
              state_nxt        = aba_pkg::ST_SCAN;
            end
            aba_pkg::REQ_REWIND: begin
              clear_fill    = 1'b1;
              out_valid_nxt = 1'b1;
            end
            aba_pkg::REQ_DESTROY: begin
              count_nxt     = '0;
              alloc_nxt     = '0;
              used_nxt      = '0;
              rsv_nxt       = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              // unknown code: no change, failed answer
              out_ok_nxt    = 1'b0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      aba_pkg::ST_SCAN: begin
        if (tok_last.valid) begin
          state_nxt     = aba_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = tok_last.found;
          if (tok_last.found) begin
            out_idx_nxt = tok_last.idx;
            out_off_nxt = tok_last.offset;
            alloc_nxt   = alloc_r + 1'b1;
            used_nxt    = used_sum[aba_pkg::USED_W] ? aba_pkg::USED_MAX
                                                   : used_sum[aba_pkg::USED_W-1:0];
            if (tok_last.created) begin
              count_nxt = count_r + 1'b1;
              rsv_nxt   = rsv_sum[aba_pkg::RSV_W] ? aba_pkg::RSV_MAX
                                                 : rsv_sum[aba_pkg::RSV_W-1:0];
            end
          end else begin
            // table full
            out_idx_nxt = '0;
            out_off_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = aba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_ok_r  <= out_ok_nxt;
    out_idx_r <= out_idx_nxt;
    out_off_r <= out_off_nxt;
    if (!rst_n) begin
      state_r      <= aba_pkg::ST_IDLE;
      count_r      <= '0;
      alloc_r      <= '0;
      used_r       <= '0;
      rsv_r        <= '0;
      dflt_r       <= aba_pkg::DFLT_SIZE_RST;
      out_valid_r  <= 1'b0;
      tok0_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      alloc_r     <= alloc_nxt;
      used_r      <= used_nxt;
      rsv_r       <= rsv_nxt;
      dflt_r      <= dflt_nxt;
      out_valid_r <= out_valid_nxt;
      tok0_r      <= tok0_nxt;
    end
  end

  // config is taken only between items
  assign cfg_ready = (state_r == aba_pkg::ST_IDLE);
  assign busy      = (state_r != aba_pkg::ST_IDLE);

  assign out_valid            = out_valid_r;
  assign out_ok               = out_ok_r;
  assign out_block_index      = out_idx_r;
  assign out_offset           = out_off_r;
  assign out_allocation_total = alloc_r;
  assign out_used_total       = used_r;
  assign out_reserved_total   = rsv_r;
  assign out_block_total      = aba_pkg::TOTAL_W'(count_r);

endmodule
